@@ rtl/pdwrl_pkg.sv @@
// Shared types, constants and helpers for the per-device window rate limiter.
package pdwrl_pkg;

  localparam int DEVICES_DEF    = 32;
  localparam int MAX_STAMPS_DEF = 8;
  localparam int MsPerSecond    = 1000;
  localparam int WIN_W          = 26;

  localparam logic CFG_MAX_PROMPTS    = 1'b0;
  localparam logic CFG_WINDOW_SECONDS = 1'b1;

  typedef struct packed {
    logic [63:0] device_key;
    logic [47:0] now_ms;
  } req_t;

  typedef struct packed {
    logic allowed;
    logic table_full;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP_RD,
    ST_SWEEP_CHK,
    ST_FIND_RD,
    ST_FIND_LD,
    ST_DROP_RD,
    ST_DROP_CHK,
    ST_DECIDE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic start;
    logic sweep_chk;
    logic find_rd;
    logic find_ld;
    logic drop_rd;
    logic drop_chk;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic found;
    logic cnt_zero;
    logic head_expired;
  } sts_t;

  function automatic logic expired(logic [47:0] now, logic [47:0] stamp,
                                   logic [WIN_W-1:0] win);
    logic [47:0] age;
    age = now - stamp;
    return (now >= stamp) && (age > {{(48-WIN_W){1'b0}}, win});
  endfunction

endpackage

@@ rtl/pdwrl_ctrl.sv @@
// Sequencer for sweep, lookup, stamp drop and grant decision.
module pdwrl_ctrl
  import pdwrl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == ST_IDLE);
    out_valid  = (state == ST_RESP);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SWEEP_RD;
        end
      end
      ST_SWEEP_RD: state_next = ST_SWEEP_CHK;
      ST_SWEEP_CHK: begin
        cmd.sweep_chk = 1'b1;
        state_next    = sts.sweep_last ? ST_FIND_RD : ST_SWEEP_RD;
      end
      ST_FIND_RD: begin
        cmd.find_rd = 1'b1;
        state_next  = sts.found ? ST_FIND_LD : ST_DECIDE;
      end
      ST_FIND_LD: begin
        cmd.find_ld = 1'b1;
        state_next  = ST_DROP_RD;
      end
      ST_DROP_RD: begin
        if (sts.cnt_zero) begin
          state_next = ST_DECIDE;
        end else begin
          cmd.drop_rd = 1'b1;
          state_next  = ST_DROP_CHK;
        end
      end
      ST_DROP_CHK: begin
        cmd.drop_chk = 1'b1;
        state_next   = sts.head_expired ? ST_DROP_RD : ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/pdwrl_dp.sv @@
// Datapath: config registers, entry table, stamp memory and result register.
module pdwrl_dp
  import pdwrl_pkg::*;
#(
  parameter int DEVICES    = DEVICES_DEF,
  parameter int MAX_STAMPS = MAX_STAMPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output rsp_t        rsp
);

  localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int SW = (MAX_STAMPS > 1) ? $clog2(MAX_STAMPS) : 1;
  localparam int CW = $clog2(MAX_STAMPS + 1);
  localparam int AW = CW + 1;
  localparam int SDEPTH = DEVICES * (2 ** SW);

  logic [3:0]  max_prompts;
  logic [15:0] window_seconds;

  logic [63:0]      in_key;
  logic [47:0]      in_now;
  logic [WIN_W-1:0] win_ms;
  logic [CW-1:0]    limit;

  logic [DEVICES-1:0] valid;
  logic [DW-1:0]      idx;
  logic               found_v, free_v;
  logic [DW-1:0]      found_idx, free_idx;

  logic [63:0]   ent_key  [DEVICES];
  logic [47:0]   ent_last [DEVICES];
  logic [SW-1:0] ent_head [DEVICES];
  logic [CW-1:0] ent_cnt  [DEVICES];
  logic [47:0]   stamps   [SDEPTH];

  logic [63:0]   rd_key;
  logic [47:0]   rd_last;
  logic [SW-1:0] rd_head;
  logic [CW-1:0] rd_cnt;
  logic [47:0]   rd_stamp;

  logic [SW-1:0] cur_head;
  logic [CW-1:0] cur_cnt;
  logic [47:0]   cur_last;

  logic [DW-1:0] ent_addr;
  logic          live, gone;
  rsp_t          rsp_next;

  function automatic logic [SW-1:0] wrap(logic [SW-1:0] a, logic [CW-1:0] b);
    logic [AW-1:0] s;
    s = AW'(a) + AW'(b);
    if (s >= AW'(MAX_STAMPS)) s = s - AW'(MAX_STAMPS);
    return s[SW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      max_prompts    <= 4'd3;
      window_seconds <= 16'd60;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_PROMPTS:    max_prompts    <= cfg_data[3:0];
        CFG_WINDOW_SECONDS: window_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(max_prompts) > MAX_STAMPS) limit = CW'(MAX_STAMPS);
    else                                limit = CW'(max_prompts);
  end

  assign ent_addr = (cmd.find_rd) ? found_idx : idx;
  assign live = valid[idx] && (rd_cnt != '0) && !expired(in_now, rd_last, win_ms);
  assign gone = valid[idx] && !live;

  assign sts.sweep_last   = (idx == DW'(DEVICES - 1));
  assign sts.found        = found_v;
  assign sts.cnt_zero     = (cur_cnt == '0);
  assign sts.head_expired = expired(in_now, rd_stamp, win_ms);

  // Grant decision for the result register
  always_comb begin
    rsp_next = '0;
    if (found_v) begin
      rsp_next.allowed = (cur_cnt < limit);
    end else if (limit != '0) begin
      rsp_next.allowed    = free_v;
      rsp_next.table_full = !free_v;
    end
  end

  // Entry table read, registered
  always_ff @(posedge clk) begin
    rd_key  <= ent_key[ent_addr];
    rd_last <= ent_last[ent_addr];
    rd_head <= ent_head[ent_addr];
    rd_cnt  <= ent_cnt[ent_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.drop_rd) rd_stamp <= stamps[{found_idx, cur_head}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      idx     <= '0;
      found_v <= 1'b0;
      free_v  <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx     <= '0;
        found_v <= 1'b0;
        free_v  <= 1'b0;
      end
      if (cmd.sweep_chk) begin
        if (gone) valid[idx] <= 1'b0;
        if (live) begin
          if (!found_v && rd_key == in_key) begin
            found_v   <= 1'b1;
            found_idx <= idx;
          end
        end else if (!free_v) begin
          free_v   <= 1'b1;
          free_idx <= idx;
        end
        if (!sts.sweep_last) idx <= idx + 1'b1;
      end
      if (cmd.decide && !found_v && limit != '0 && free_v) valid[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      in_key <= req.device_key;
      in_now <= req.now_ms;
      win_ms <= WIN_W'(window_seconds) * WIN_W'(MsPerSecond);
    end
    if (cmd.find_ld) begin
      cur_head <= rd_head;
      cur_cnt  <= rd_cnt;
      cur_last <= rd_last;
    end
    if (cmd.drop_chk && sts.head_expired) begin
      cur_head <= wrap(cur_head, CW'(1));
      cur_cnt  <= cur_cnt - 1'b1;
    end
    if (cmd.decide) begin
      rsp <= rsp_next;
      if (found_v) begin
        ent_key[found_idx]  <= in_key;
        ent_head[found_idx] <= cur_head;
        if (cur_cnt < limit) begin
          stamps[{found_idx, wrap(cur_head, cur_cnt)}] <= in_now;
          ent_cnt[found_idx]  <= cur_cnt + 1'b1;
          ent_last[found_idx] <= in_now;
        end else begin
          ent_cnt[found_idx]  <= cur_cnt;
          ent_last[found_idx] <= cur_last;
        end
      end else if (limit != '0) begin
        if (free_v) begin
          ent_key[free_idx]          <= in_key;
          ent_head[free_idx]         <= '0;
          ent_cnt[free_idx]          <= CW'(1);
          ent_last[free_idx]         <= in_now;
          stamps[{free_idx, SW'(0)}] <= in_now;
        end
      end
    end
  end

endmodule

@@ rtl/per_device_window_rate_limiter_unit.sv @@
// Per-device window rate limiter: top level.
// Each request runs the entry sweep (one registered table read and check per entry), the
// lookup, for a known device the head-stamp drop loop over expired stamps, and then the
// grant decision and the result beat.
// One item at a time; the next input beat can be taken in the cycle after the result beat.
// Reset (rst, synchronous): all entries invalid, max_prompts = 3, window_seconds = 60.
// Stamp and key storage is not cleared; only entries marked valid are used.
module per_device_window_rate_limiter_unit
  import pdwrl_pkg::*;
#(
  parameter int DEVICES    = DEVICES_DEF,
  parameter int MAX_STAMPS = MAX_STAMPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Config writes are always taken; they must arrive only while the block is idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  pdwrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath holds the table, the stamp memory and the result register.
  pdwrl_dp #(
    .DEVICES    (DEVICES),
    .MAX_STAMPS (MAX_STAMPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (out_data)
  );

endmodule

@@ test/per_device_window_rate_limiter_unit_chk.sv @@
// Checker for the window rate limiter: predicts each verdict and compares result beats.
module per_device_window_rate_limiter_unit_chk
  import pdwrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  req_t        in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  rsp_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          verdicts_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDEV = 32;
  localparam int NSTAMP = 8;

  logic [3:0]  lim_reg;
  logic [15:0] win_reg;
  logic        dev_live [NDEV];
  logic [63:0] dev_key [NDEV];
  logic [47:0] dev_stamp [NDEV][NSTAMP];
  logic [2:0]  dev_head [NDEV];
  logic [3:0]  dev_cnt [NDEV];
  rsp_t        verdict_q[$];

  assign verdicts_pending = verdict_q.size();

  function automatic logic stale(logic [47:0] stamp, logic [47:0] now, logic [31:0] w);
    if (now < stamp) return 1'b0;
    return ({16'd0, now - stamp} > {32'd0, w});
  endfunction

  // Advance the limiter state for one request and return its verdict.
  function automatic rsp_t grant_verdict(req_t r);
    rsp_t v;
    logic [31:0] w;
    int lim, hit, spare;
    logic [2:0] last, tail;
    w = win_reg * 32'd1000;
    lim = (lim_reg > NSTAMP) ? NSTAMP : lim_reg;
    hit = -1;
    spare = -1;
    v = '0;
    for (int d = 0; d < NDEV; d++) begin
      if (dev_live[d]) begin
        if (dev_cnt[d] == 0) dev_live[d] = 1'b0;
        else begin
          last = dev_head[d] + 3'(dev_cnt[d] - 1);
          if (stale(dev_stamp[d][last], r.now_ms, w)) dev_live[d] = 1'b0;
        end
      end
    end
    for (int d = 0; d < NDEV; d++) begin
      if (dev_live[d]) begin
        if (hit < 0 && dev_key[d] == r.device_key) hit = d;
      end else if (spare < 0) spare = d;
    end
    if (hit >= 0) begin
      while (dev_cnt[hit] > 0 && stale(dev_stamp[hit][dev_head[hit]], r.now_ms, w)) begin
        dev_head[hit] = dev_head[hit] + 3'd1;
        dev_cnt[hit] = dev_cnt[hit] - 4'd1;
      end
      if (dev_cnt[hit] < lim) begin
        tail = dev_head[hit] + 3'(dev_cnt[hit]);
        dev_stamp[hit][tail] = r.now_ms;
        dev_cnt[hit] = dev_cnt[hit] + 4'd1;
        v.allowed = 1'b1;
      end
    end else if (lim > 0) begin
      if (spare < 0) v.table_full = 1'b1;
      else begin
        dev_live[spare] = 1'b1;
        dev_key[spare] = r.device_key;
        dev_head[spare] = '0;
        dev_cnt[spare] = 4'd1;
        dev_stamp[spare][0] = r.now_ms;
        v.allowed = 1'b1;
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch at %0t: %s got %0b expected %0b", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      lim_reg <= 4'd3;
      win_reg <= 16'd60;
      for (int d = 0; d < NDEV; d++) dev_live[d] = 1'b0;
      verdict_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_PROMPTS) lim_reg <= cfg_data[3:0];
        else win_reg <= cfg_data;
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1'b1, 1'b0);
        end else begin
          want = verdict_q.pop_front();
          if (out_data.allowed !== want.allowed)
            report_mismatch("allowed", out_data.allowed, want.allowed);
          if (out_data.table_full !== want.table_full)
            report_mismatch("table_full", out_data.table_full, want.table_full);
        end
      end
      if (in_valid && in_ready) verdict_q.push_back(grant_verdict(in_data));
    end
  end
endmodule

@@ test/per_device_window_rate_limiter_unit_tb.sv @@
// Testbench top: drives requests and register writes, stalls both sides, gives the verdict.
module per_device_window_rate_limiter_unit_tb;
  import pdwrl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE = 2 * 32 + 4 + 2 * 8 + 20;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          verdicts_pending;

  // Clock time base for requests; mostly moves forward, but is set back before the random phases.
  logic [47:0] clock_ms = '0;
  logic [63:0] key_pool [16];
  bit          hold_sink = 1'b0;
  int          idle_cycles = 0;

  always #4 clk = ~clk;

  per_device_window_rate_limiter_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  per_device_window_rate_limiter_unit_chk u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .verdicts_pending(verdicts_pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random ready, with a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_sink) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog: count cycles with no beat on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("per_device_window_rate_limiter_unit verification failed");
      $finish;
    end
  end

  task automatic send_req(logic [63:0] key, logic [47:0] now);
    repeat (gap_len() / 2 + 1) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= '{device_key: key, now_ms: now};
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: mostly reuse of a small key pool, time stepping in ms or seconds.
  task automatic random_phase(int n, int win_s);
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: k = {$urandom, $urandom};
        default: k = key_pool[$urandom_range(0, 15)];
      endcase
      case ($urandom_range(0, 5))
        0, 1, 2: clock_ms = clock_ms + $urandom_range(0, 50);
        3, 4: clock_ms = clock_ms + $urandom_range(0, win_s * 400 + 10);
        default: clock_ms = clock_ms + win_s * 1000 + $urandom_range(0, 2);
      endcase
      send_req(k, clock_ms);
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: key extremes, limit of three reached, exact window edge.
    clock_ms = 48'd1000;
    send_req(64'd0, clock_ms);
    send_req(64'hFFFF_FFFF_FFFF_FFFF, clock_ms);
    send_req(64'd0, clock_ms);
    send_req(64'd0, clock_ms);
    send_req(64'd0, clock_ms);
    send_req(64'd0, clock_ms + 48'd60000);
    send_req(64'd0, clock_ms + 48'd60001);
    clock_ms = clock_ms + 48'd60001;
    // Time going backward: stamp newer than now counts as live.
    send_req(64'd0, clock_ms - 48'd500);
    drain();

    // Full table with a long window: 32 devices then a 33rd.
    write_reg(CFG_WINDOW_SECONDS, 16'hFFFF);
    write_reg(CFG_MAX_PROMPTS, 16'd8);
    for (int i = 0; i < 33; i++) send_req(64'h100 + i, clock_ms);
    drain();
    // Limit above store depth, then lowered below live count.
    write_reg(CFG_MAX_PROMPTS, 16'd15);
    for (int i = 0; i < 9; i++) send_req(64'h100, clock_ms);
    drain();
    write_reg(CFG_MAX_PROMPTS, 16'd2);
    send_req(64'h100, clock_ms);
    drain();
    // Zero limit: refused, no entry, no full flag.
    write_reg(CFG_MAX_PROMPTS, 16'd0);
    send_req(64'hDEAD, clock_ms);
    send_req(64'h100, clock_ms);
    drain();
    // Zero window clears everything older than now; near-max time.
    write_reg(CFG_WINDOW_SECONDS, 16'd0);
    write_reg(CFG_MAX_PROMPTS, 16'd1);
    clock_ms = 48'hFFFF_FFFF_0000;
    send_req(64'h100, clock_ms);
    send_req(64'h100, clock_ms);
    drain();

    // Random phases across settings.
    clock_ms = 48'd5;
    write_reg(CFG_WINDOW_SECONDS, 16'd1);
    write_reg(CFG_MAX_PROMPTS, 16'd3);
    random_phase(100, 1);
    drain();
    write_reg(CFG_WINDOW_SECONDS, 16'd2);
    write_reg(CFG_MAX_PROMPTS, 16'd8);
    // Hold the receiver off while the sender keeps offering.
    fork
      begin
        hold_sink = 1'b1;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end
      random_phase(100, 2);
    join
    drain();
    write_reg(CFG_WINDOW_SECONDS, 16'd0);
    write_reg(CFG_MAX_PROMPTS, 16'd1);
    random_phase(60, 0);
    drain();
    write_reg(CFG_WINDOW_SECONDS, 16'hFFFF);
    write_reg(CFG_MAX_PROMPTS, 16'd5);
    random_phase(80, 1);
    drain();
    write_reg(CFG_WINDOW_SECONDS, 16'd3);
    write_reg(CFG_MAX_PROMPTS, 16'd2);
    clock_ms = clock_ms + 48'h8000_0000_0000;
    random_phase(60, 3);
    drain();

    if (fail_count == 0)
      $display("per_device_window_rate_limiter_unit verification clean");
    else
      $display("per_device_window_rate_limiter_unit verification failed");
    $finish;
  end
endmodule

@@ per_device_window_rate_limiter_unit.f @@
rtl/pdwrl_pkg.sv
rtl/pdwrl_ctrl.sv
rtl/pdwrl_dp.sv
rtl/per_device_window_rate_limiter_unit.sv
test/per_device_window_rate_limiter_unit_chk.sv
test/per_device_window_rate_limiter_unit_tb.sv
